### src/assert_macros.svh
// Assertion macros for the checker file of the voice channel allocator.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, off while reset is asserted.
`define VCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication, off while reset is asserted.
`define VCA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked through reset as well.
`define VCA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/vca_pkg.sv
// Package of the voice channel allocator: field widths, defaults, codes and types.
// No dependencies; used by every other file of the block but assert_macros.svh.
`default_nettype none

package vca_pkg;

  // Parameter defaults
  localparam int CHANNELS_DEF  = 15;
  localparam int NOTE_BITS_DEF = 16;
  localparam int BEAT_BITS_DEF = 32;

  // Fixed port field widths
  localparam int KIND_W    = 1;
  localparam int NOTE_W    = 16;
  localparam int BEAT_W    = 32;
  localparam int SPAN_CH_W = 4;
  localparam int AGE_W     = 32;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_END   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_START = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Control from the sequencer to the scan unit
  typedef struct packed {
    logic clr;
    logic vld;
    logic start_mode;
    logic entry_active;
  } scan_ctrl_t;

  // Status from the scan unit back to the sequencer
  typedef struct packed {
    logic found;
    logic emit;
    logic stolen;
  } scan_stat_t;

endpackage

`default_nettype wire

### src/vca_if.sv
// Channel interfaces of the voice channel allocator: note events in, closed spans out.
// Depends on vca_pkg for field widths.
`default_nettype none

interface vca_in_if import vca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [NOTE_W-1:0] note_id;
  logic [BEAT_W-1:0] beat_time;

  modport source (output valid, kind, note_id, beat_time, input ready);
  modport sink   (input valid, kind, note_id, beat_time, output ready);
endinterface

interface vca_out_if import vca_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SPAN_CH_W-1:0] span_channel;
  logic [NOTE_W-1:0]    span_note;
  logic [BEAT_W-1:0]    span_begin;
  logic [BEAT_W-1:0]    span_end;
  logic                 span_stolen;

  modport source (output valid, span_channel, span_note, span_begin, span_end, span_stolen,
                  input ready);
  modport sink   (input valid, span_channel, span_note, span_begin, span_end, span_stolen,
                  output ready);
endinterface

`default_nettype wire

### src/vca_voice_mem.sv
// Per-channel voice store: note, start beat and activation age, one entry per channel.
// Depends on vca_pkg; one write port, one registered read port.
`default_nettype none

module vca_voice_mem import vca_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int NOTE_BITS = NOTE_BITS_DEF,
  parameter int BEAT_BITS = BEAT_BITS_DEF,
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [CH_W-1:0]      waddr,
  input  wire logic [NOTE_BITS-1:0] wnote,
  input  wire logic [BEAT_BITS-1:0] wbegin,
  input  wire logic [AGE_W-1:0]     wage,
  input  wire logic                 re,
  input  wire logic [CH_W-1:0]      raddr,
  output logic      [NOTE_BITS-1:0] rnote,
  output logic      [BEAT_BITS-1:0] rbegin,
  output logic      [AGE_W-1:0]     rage
);

  logic [NOTE_BITS-1:0] note_mem  [CHANNELS];
  logic [BEAT_BITS-1:0] begin_mem [CHANNELS];
  logic [AGE_W-1:0]     age_mem   [CHANNELS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      note_mem[waddr]  <= wnote;
      begin_mem[waddr] <= wbegin;
      age_mem[waddr]   <= wage;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rnote  <= note_mem[raddr];
      rbegin <= begin_mem[raddr];
      rage   <= age_mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/vca_scan_unit.sv
// Shared compare unit: looks at one channel entry per cycle and keeps the running pick
// (first free, oldest voice, or first matching note). Depends on vca_pkg.
`default_nettype none

module vca_scan_unit import vca_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int NOTE_BITS = NOTE_BITS_DEF,
  parameter int BEAT_BITS = BEAT_BITS_DEF,
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire scan_ctrl_t           ctrl,
  input  wire logic [CH_W-1:0]      idx,
  input  wire logic [NOTE_BITS-1:0] entry_note,
  input  wire logic [BEAT_BITS-1:0] entry_begin,
  input  wire logic [AGE_W-1:0]     entry_age,
  input  wire logic [NOTE_BITS-1:0] item_note,
  input  wire logic [AGE_W-1:0]     count,
  output scan_stat_t                stat,
  output logic      [CH_W-1:0]      sel_ch,
  output logic      [NOTE_BITS-1:0] sel_note,
  output logic      [BEAT_BITS-1:0] sel_begin
);

  logic                 found_r;
  logic                 have_best_r;
  logic [CH_W-1:0]      free_ch_r;
  logic [CH_W-1:0]      best_ch_r;
  logic [AGE_W-1:0]     best_dist_r;
  logic [NOTE_BITS-1:0] best_note_r;
  logic [BEAT_BITS-1:0] best_begin_r;

  logic [AGE_W-1:0] age_gap;
  logic             take_free;
  logic             take_best;
  logic             take_match;

  // Age distance, modulo 2^32
  assign age_gap = count - entry_age;

  // Decisions for the entry on hand
  always_comb begin
    take_free  = 1'b0;
    take_best  = 1'b0;
    take_match = 1'b0;
    if (ctrl.vld && !found_r) begin
      if (ctrl.start_mode) begin
        take_free = !ctrl.entry_active;
        take_best = ctrl.entry_active && (!have_best_r || (age_gap > best_dist_r));
      end else begin
        take_match = ctrl.entry_active && (entry_note == item_note);
      end
    end
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      have_best_r <= 1'b0;
    end else if (ctrl.clr) begin
      found_r     <= 1'b0;
      have_best_r <= 1'b0;
    end else begin
      if (take_free || take_match) found_r <= 1'b1;
      if (take_best) have_best_r <= 1'b1;
    end
  end

  // Candidate payload; a matching note reuses the oldest-voice slot
  always_ff @(posedge clk) begin
    if (take_free) free_ch_r <= idx;
    if (take_best) best_dist_r <= age_gap;
    if (take_best || take_match) begin
      best_ch_r    <= idx;
      best_note_r  <= entry_note;
      best_begin_r <= entry_begin;
    end
  end

  // Result of the scan
  assign stat.found  = found_r;
  assign stat.stolen = ctrl.start_mode && !found_r;
  assign stat.emit   = ctrl.start_mode ? !found_r : found_r;
  assign sel_ch      = (ctrl.start_mode && found_r) ? free_ch_r : best_ch_r;
  assign sel_note    = best_note_r;
  assign sel_begin   = best_begin_r;

endmodule

`default_nettype wire

### src/voice_channel_allocator_core.sv
// Top level of the voice channel allocator: sequencer, active flags, activation counter
// and span output register. Depends on vca_pkg, vca_if, vca_voice_mem, vca_scan_unit.
//
//  channel   dir  payload                                            transfer
//  in_chan   in   kind, note_id, beat_time                           valid && ready
//  out_chan  out  span_channel, span_note, span_begin, span_end,     valid && ready
//                 span_stolen
//
// Each event passes the scan, drain and done states: the scan reads one channel
// per cycle through the single read port of the voice store, then a drain and a commit.
// in_chan.ready is high only while the sequencer is idle.
// Commit waits while a span is due and the output register still holds an untaken span.
// Reset (rst_n low, synchronous) clears the active flags, the counter and out valid;
// the voice store needs no clearing.
`default_nettype none

module voice_channel_allocator_core import vca_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int NOTE_BITS = NOTE_BITS_DEF,
  parameter int BEAT_BITS = BEAT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  vca_in_if.sink    in_chan,
  vca_out_if.source out_chan
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  state_t state_r, state_nxt;

  logic [KIND_W-1:0]    kind_r;
  logic [NOTE_BITS-1:0] note_r;
  logic [BEAT_BITS-1:0] beat_r;
  logic [CH_W-1:0]      rd_idx_r;
  logic [CH_W-1:0]      idx_d_r;
  logic                 scan_vld_r;
  logic [CHANNELS-1:0]  active_r;
  logic [AGE_W-1:0]     count_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [SPAN_CH_W-1:0] out_ch_r;
  logic [NOTE_W-1:0]    out_note_r;
  logic [BEAT_W-1:0]    out_begin_r;
  logic [BEAT_W-1:0]    out_end_r;
  logic                 out_stolen_r;

  logic                 in_ready;
  logic                 accept;
  logic                 rd_en;
  logic                 commit;
  logic                 load_out;
  logic                 is_start;

  scan_ctrl_t           ctrl;
  scan_stat_t           stat;
  logic [CH_W-1:0]      sel_ch;
  logic [NOTE_BITS-1:0] sel_note;
  logic [BEAT_BITS-1:0] sel_begin;
  logic [NOTE_BITS-1:0] rd_note;
  logic [BEAT_BITS-1:0] rd_begin;
  logic [AGE_W-1:0]     rd_age;

  assign is_start = (kind_r == KIND_START);
  assign accept   = in_chan.valid && in_ready;
  assign load_out = commit && stat.emit;

  // Sequencer: next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (rd_idx_r == LAST_CH) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.emit || !out_valid_r || out_chan.ready) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Event capture
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_chan.kind;
      note_r <= NOTE_BITS'(in_chan.note_id);
      beat_r <= BEAT_BITS'(in_chan.beat_time);
    end
  end

  // Scan address and read pipeline tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r   <= '0;
      scan_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        rd_idx_r <= '0;
      end else if (rd_en && (rd_idx_r != LAST_CH)) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      scan_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r <= rd_idx_r;
  end

  // Active flags and activation counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      count_r  <= '0;
    end else if (commit) begin
      if (is_start) begin
        active_r[sel_ch] <= 1'b1;
        count_r          <= count_r + 1'b1;
      end else if (stat.found) begin
        active_r[sel_ch] <= 1'b0;
      end
    end
  end

  // Voice store
  vca_voice_mem #(
    .CHANNELS  (CHANNELS),
    .NOTE_BITS (NOTE_BITS),
    .BEAT_BITS (BEAT_BITS)
  ) u_mem (
    .clk    (clk),
    .we     (commit && is_start),
    .waddr  (sel_ch),
    .wnote  (note_r),
    .wbegin (beat_r),
    .wage   (count_r),
    .re     (rd_en),
    .raddr  (rd_idx_r),
    .rnote  (rd_note),
    .rbegin (rd_begin),
    .rage   (rd_age)
  );

  // Shared compare unit
  assign ctrl.clr          = accept;
  assign ctrl.vld          = scan_vld_r;
  assign ctrl.start_mode   = is_start;
  assign ctrl.entry_active = active_r[idx_d_r];

  vca_scan_unit #(
    .CHANNELS  (CHANNELS),
    .NOTE_BITS (NOTE_BITS),
    .BEAT_BITS (BEAT_BITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .idx         (idx_d_r),
    .entry_note  (rd_note),
    .entry_begin (rd_begin),
    .entry_age   (rd_age),
    .item_note   (note_r),
    .count       (count_r),
    .stat        (stat),
    .sel_ch      (sel_ch),
    .sel_note    (sel_note),
    .sel_begin   (sel_begin)
  );

  // Span output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch_r     <= SPAN_CH_W'(sel_ch);
      out_note_r   <= NOTE_W'(sel_note);
      out_begin_r  <= BEAT_W'(sel_begin);
      out_end_r    <= BEAT_W'(beat_r);
      out_stolen_r <= stat.stolen;
    end
  end

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.span_channel = out_ch_r;
  assign out_chan.span_note    = out_note_r;
  assign out_chan.span_begin   = out_begin_r;
  assign out_chan.span_end     = out_end_r;
  assign out_chan.span_stolen  = out_stolen_r;

endmodule

`default_nettype wire

### src/vca_checker.sv
// Port-level checks of the voice channel allocator, bound to the top level.
// Depends on vca_pkg, assert_macros.svh and the top level's ports.
`default_nettype none
`include "assert_macros.svh"

module vca_checker import vca_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [SPAN_CH_W-1:0] span_channel,
  input wire logic [NOTE_W-1:0]    span_note,
  input wire logic [BEAT_W-1:0]    span_begin,
  input wire logic [BEAT_W-1:0]    span_end,
  input wire logic                 span_stolen
);

  // A stalled span holds
  `VCA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(span_channel) && $stable(span_note) && $stable(span_begin) && $stable(span_end) && $stable(span_stolen), "stalled span changed")

  // Busy after taking an event
  `VCA_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "ready right after a transfer")

  // Channel in range
  `VCA_ASSERT_NOW(a_ch_range, clk, rst_n, out_valid, 32'(span_channel) < CHANNELS, "span channel out of range")

  // Reset leaves the block idle and empty
  `VCA_ASSERT_NEXT_ALWAYS(a_reset, clk, !rst_n, !out_valid && in_ready, "not idle after reset")

endmodule

bind voice_channel_allocator_core vca_checker #(.CHANNELS(CHANNELS)) u_vca_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .span_channel (out_chan.span_channel),
  .span_note    (out_chan.span_note),
  .span_begin   (out_chan.span_begin),
  .span_end     (out_chan.span_end),
  .span_stolen  (out_chan.span_stolen)
);

`default_nettype wire
